### rtl/core/census_transform_3x3_macros.svh
// assertion macros for the census transform core
// expects clk and rst_n in the scope of every use
`ifndef CENSUS_TRANSFORM_3X3_MACROS_SVH
`define CENSUS_TRANSFORM_3X3_MACROS_SVH

// same-cycle implication
`define CT3_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("census transform: assertion failed");

// next-cycle implication
`define CT3_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("census transform: assertion failed");

`endif

### rtl/core/ct3_pkg.sv
// shared types, constants and the census compare function
// no dependencies
`timescale 1ns / 1ps

package ct3_pkg;

    localparam int PIXEL_BITS        = 8;
    localparam int DEFAULT_MAX_WIDTH = 1024;
    localparam int HEIGHT_LIMIT      = 4096;
    localparam int WIDTH_CFG_BITS    = 11;
    localparam int HEIGHT_CFG_BITS   = 13;
    localparam int CFG_DATA_BITS     = 13;
    localparam int ROW_BITS          = 12;
    localparam int OUT_DEPTH         = 8;

    localparam logic [WIDTH_CFG_BITS-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_CFG_BITS-1:0] HEIGHT_RESET = 13'd480;

    // register indexes
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef logic [PIXEL_BITS-1:0] pix_t;

    typedef struct packed {
        logic clear_win;
        logic emit;
        logic last_col;
        logic frame_end;
    } stage_ctrl_t;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
        logic       done;
    } result_t;

    // neighbours in order tl, t, tr, l, r, bl, b, br
    function automatic logic [7:0] census_bits(input pix_t [7:0] nb, input pix_t centre);
        logic [7:0] bits;
        bits = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (nb[i] > centre)
            begin
                bits[i] = 1'b1;
            end
        end
        return bits;
    endfunction

endpackage

### rtl/core/ct3_position.sv
// raster position tracking: column and row counters with size clamping
// depends on ct3_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "census_transform_3x3_macros.svh"

module ct3_position #(
    parameter int MAX_WIDTH = ct3_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 accept,
    input  logic                                 frame_start,
    input  logic [ct3_pkg::WIDTH_CFG_BITS-1:0]   frame_width,
    input  logic [ct3_pkg::HEIGHT_CFG_BITS-1:0]  frame_height,
    output logic [$clog2(MAX_WIDTH)-1:0]         col,
    output ct3_pkg::stage_ctrl_t                 ctrl
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = ct3_pkg::ROW_BITS;
    localparam int HW = ct3_pkg::HEIGHT_CFG_BITS;

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [WW-1:0] w_use;
    logic [HW-1:0] h_use;
    logic [CW-1:0] c_cur;
    logic [HW-1:0] r_step;
    logic [RW-1:0] r_cur;
    logic          last_col;
    logic          last_row;

    always_comb
    begin
        if (32'(frame_width) > MAX_WIDTH)
            w_use = WW'(MAX_WIDTH);
        else if (frame_width < 11'd2)
            w_use = WW'(2);
        else
            w_use = WW'(frame_width);

        if (32'(frame_height) > ct3_pkg::HEIGHT_LIMIT)
            h_use = HW'(ct3_pkg::HEIGHT_LIMIT);
        else if (frame_height < 13'd3)
            h_use = 13'd3;
        else
            h_use = frame_height;
    end

    // position of this item, after restart and shrunken-size fixups
    always_comb
    begin
        c_cur  = col_reg;
        r_step = HW'(row_reg);
        if (frame_start)
        begin
            c_cur  = '0;
            r_step = '0;
        end
        if (WW'(c_cur) >= w_use)
        begin
            c_cur  = '0;
            r_step = r_step + 1'b1;
        end
        if (r_step >= h_use)
            r_step = '0;
        r_cur = RW'(r_step);

        last_col = (WW'(c_cur) == w_use - 1'b1);
        last_row = (HW'(r_cur) == h_use - 1'b1);

        if (last_col)
        begin
            col_next = '0;
            row_next = last_row ? '0 : r_cur + 1'b1;
        end
        else
        begin
            col_next = c_cur + 1'b1;
            row_next = r_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign col            = c_cur;
    assign ctrl.clear_win = (c_cur == '0);
    assign ctrl.emit      = (r_cur >= RW'(2)) && (c_cur != '0);
    assign ctrl.last_col  = last_col;
    assign ctrl.frame_end = last_row;

    `CT3_ASSERT_NEXT(wrap_after_last_col, accept && last_col, col_reg == '0)

endmodule

### rtl/core/ct3_line_mem.sv
// line buffer memory: both previous rows packed in one word per column
// one read and one write per cycle with same-address bypass; depends on ct3_pkg
`timescale 1ns / 1ps

module ct3_line_mem #(
    parameter int MAX_WIDTH = ct3_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]         rd_addr,
    output logic [2*ct3_pkg::PIXEL_BITS-1:0]     rd_data,
    input  logic                                 wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]         wr_addr,
    input  logic [2*ct3_pkg::PIXEL_BITS-1:0]     wr_data
);

    localparam int DW = 2 * ct3_pkg::PIXEL_BITS;

    logic [DW-1:0] mem [MAX_WIDTH];
    logic [DW-1:0] q_reg;
    logic [DW-1:0] byp_data_reg;
    logic          byp_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
        begin
            q_reg        <= mem[rd_addr];
            byp_data_reg <= wr_data;
        end
    end

    // a write landing on the entry being read wins over the stale array word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byp_reg <= 1'b0;
        else if (rd_en)
            byp_reg <= wr_en && (wr_addr == rd_addr);
    end

    assign rd_data = byp_reg ? byp_data_reg : q_reg;

endmodule

### rtl/core/ct3_window.sv
// 3x3 window registers and census code generation for one or two results
// depends on ct3_pkg
`timescale 1ns / 1ps

module ct3_window (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  valid,
    input  ct3_pkg::stage_ctrl_t  ctrl,
    input  ct3_pkg::pix_t         pixel,
    input  ct3_pkg::pix_t         top_pix,
    input  ct3_pkg::pix_t         mid_pix,
    output logic                  push_a,
    output logic                  push_b,
    output ct3_pkg::result_t      res_a,
    output ct3_pkg::result_t      res_b
);

    // entries 0..2: column x-2 (top, mid, bottom), 3..5: column x-1
    ct3_pkg::pix_t win_reg [6];
    ct3_pkg::pix_t wl [6];

    always_comb
    begin
        for (int i = 0; i < 6; i++)
            wl[i] = ctrl.clear_win ? '0 : win_reg[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                win_reg[i] <= '0;
        end
        else if (valid)
        begin
            win_reg[0] <= wl[3];
            win_reg[1] <= wl[4];
            win_reg[2] <= wl[5];
            win_reg[3] <= top_pix;
            win_reg[4] <= mid_pix;
            win_reg[5] <= pixel;
        end
    end

    assign res_a.code = ct3_pkg::census_bits({pixel, wl[5], wl[2], mid_pix,
                                              wl[1], top_pix, wl[3], wl[0]}, wl[4]);
    assign res_a.last = !ctrl.last_col;
    assign res_a.done = 1'b0;

    // last column: right-hand neighbours lie outside the image
    assign res_b.code = ct3_pkg::census_bits({8'h00, pixel, wl[5], 8'h00,
                                              wl[4], 8'h00, top_pix, wl[3]}, mid_pix);
    assign res_b.last = 1'b1;
    assign res_b.done = ctrl.frame_end;

    assign push_a = valid && ctrl.emit;
    assign push_b = valid && ctrl.emit && ctrl.last_col;

endmodule

### rtl/core/ct3_out_fifo.sv
// output queue: up to two results in a cycle, one out if unstalled
// depends on ct3_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "census_transform_3x3_macros.svh"

module ct3_out_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_a,
    input  logic              push_b,
    input  ct3_pkg::result_t  res_a,
    input  ct3_pkg::result_t  res_b,
    input  logic              reserve,
    output logic              can_accept,
    output logic              out_valid,
    input  logic              out_stall,
    output ct3_pkg::result_t  head
);

    localparam int DEPTH = ct3_pkg::OUT_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int NW    = $clog2(DEPTH + 1);

    ct3_pkg::result_t entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] count_reg, count_next;
    logic          pop;

    assign pop = out_valid && !out_stall;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PW'(push_a) + PW'(push_b);
        rd_ptr_next = rd_ptr_reg + PW'(pop);
        count_next  = count_reg + NW'(push_a) + NW'(push_b) - NW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_a)
            entry_reg[wr_ptr_reg] <= res_a;
        if (push_b)
            entry_reg[wr_ptr_reg + 1'b1] <= res_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // an item in flight may still add two results
    assign can_accept = (32'(count_reg) + (reserve ? 2 : 0)) <= DEPTH - 2;
    assign out_valid  = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];

    `CT3_ASSERT_NOW(no_overflow_on_pair, push_b, 32'(count_reg) <= DEPTH - 2)

endmodule

### rtl/core/census_transform_3x3.sv
// top level of the streaming 3x3 census transform
// depends on ct3_pkg, ct3_position, ct3_line_mem, ct3_window, ct3_out_fifo
`timescale 1ns / 1ps
`include "census_transform_3x3_macros.svh"

// usage
//   input channel: pixel and frame_start, taken when in_valid is high and
//   in_stall low; pixels arrive in raster order, frame_start on pixel (0,0)
//   output channel: census_code, last_in_run, frame_done, taken when
//   out_valid is high and out_stall low
//   configuration: cfg_write with cfg_index 0 (frame_width) or 1
//   (frame_height); write only while the block is idle
//   one item per clock while in_stall is low; an item's line buffer word is
//   read at the accepting edge, the next cycle forms the codes and writes the
//   column back, and with an empty queue its first result is output in the
//   cycle after; an item on the last column of a band row gives two results,
//   both queued in an eight-entry output queue that runs at one result per
//   cycle while out_stall is low; when the receiver stalls the queue fills and
//   in_stall rises once fewer than two free slots remain beyond those claimed
//   by the item in flight; reset clears position counters, window and queue
//   and restores the default 640 x 480 size; the line buffer needs no clearing
module census_transform_3x3 #(
    parameter int MAX_WIDTH = ct3_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [ct3_pkg::PIXEL_BITS-1:0]     pixel,
    input  logic                               frame_start,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [7:0]                         census_code,
    output logic                               last_in_run,
    output logic                               frame_done,
    input  logic                               cfg_write,
    input  logic                               cfg_index,
    input  logic [ct3_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int PB = ct3_pkg::PIXEL_BITS;

    logic [ct3_pkg::WIDTH_CFG_BITS-1:0]  frame_width_reg;
    logic [ct3_pkg::HEIGHT_CFG_BITS-1:0] frame_height_reg;

    logic                  accept;
    logic [AW-1:0]         col;
    ct3_pkg::stage_ctrl_t  ctrl;

    logic                  s1_valid_reg;
    ct3_pkg::stage_ctrl_t  s1_ctrl_reg;
    ct3_pkg::pix_t         s1_pixel_reg;
    logic [AW-1:0]         s1_addr_reg;

    logic [2*PB-1:0]       rd_data;
    ct3_pkg::pix_t         top_pix;
    ct3_pkg::pix_t         mid_pix;

    logic                  push_a, push_b;
    ct3_pkg::result_t      res_a, res_b, head;
    logic                  can_accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= ct3_pkg::WIDTH_RESET;
            frame_height_reg <= ct3_pkg::HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                ct3_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[ct3_pkg::WIDTH_CFG_BITS-1:0];
                ct3_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_stall = !can_accept;
    assign accept   = in_valid && !in_stall;

    ct3_position #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_position (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .frame_start  (frame_start),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .col          (col),
        .ctrl         (ctrl)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ctrl_reg  <= ctrl;
            s1_pixel_reg <= pixel;
            s1_addr_reg  <= col;
        end
    end

    // word layout: low byte row y-2, high byte row y-1
    ct3_line_mem #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (col),
        .rd_data (rd_data),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_addr_reg),
        .wr_data ({s1_pixel_reg, mid_pix})
    );

    assign top_pix = rd_data[PB-1:0];
    assign mid_pix = rd_data[2*PB-1:PB];

    ct3_window u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .valid   (s1_valid_reg),
        .ctrl    (s1_ctrl_reg),
        .pixel   (s1_pixel_reg),
        .top_pix (top_pix),
        .mid_pix (mid_pix),
        .push_a  (push_a),
        .push_b  (push_b),
        .res_a   (res_a),
        .res_b   (res_b)
    );

    ct3_out_fifo u_out_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_a     (push_a),
        .push_b     (push_b),
        .res_a      (res_a),
        .res_b      (res_b),
        .reserve    (s1_valid_reg),
        .can_accept (can_accept),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .head       (head)
    );

    assign census_code = head.code;
    assign last_in_run = head.last;
    assign frame_done  = head.done;

    `CT3_ASSERT_NOW(done_is_last, out_valid && frame_done, last_in_run)

endmodule
